### hw/rtl/tpht_pkg.sv
// ----------------------------------------------------------------------------
// tpht_pkg
// Shared sizes, types and port structs for the two-peaks histogram threshold.
// ----------------------------------------------------------------------------
package tpht_pkg;

    localparam int NUM_BINS = 256;
    localparam int COUNT_W  = 32;
    localparam int BIN_W    = $clog2(NUM_BINS);
    localparam int PIX_W    = 8;
    localparam int OUT_W    = 8;
    localparam int DIST2_W  = 2 * BIN_W;
    localparam int SCORE_W  = DIST2_W + COUNT_W;

    typedef logic [BIN_W-1:0]   bin_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [DIST2_W-1:0] dist2_t;
    typedef logic [SCORE_W-1:0] score_t;

    // histogram memory access, one read and one write port
    typedef struct packed {
        logic   rd_en;
        bin_t   rd_addr;
        logic   wr_en;
        bin_t   wr_addr;
        count_t wr_data;
        logic   clear;
    } mem_req_t;

    // second-peak scoring request: bin, distance to first peak, count
    typedef struct packed {
        logic   valid;
        bin_t   idx;
        bin_t   delta;
        count_t count;
    } score_req_t;

    typedef struct packed {
        logic   valid;
        bin_t   idx;
        score_t score;
    } score_rsp_t;

endpackage

### hw/rtl/two_peaks_histogram_threshold.sv
// ----------------------------------------------------------------------------
// two_peaks_histogram_threshold
// Counts gray pixels of a frame into a saturating histogram; on the last pixel
// finds the first peak, the distance-weighted second peak and the valley
// between them, sends the three bins as one word and clears the histogram.
//
//   channel  | dir | tdata                       | tuser | tlast
//   s_*      | in  | [7:0] pixel_value           | -     | last_pixel
//   m_*      | out | [7:0] threshold_level,      | -     | -
//            |     | [15:8] first_peak,          |       |
//            |     | [23:16] second_peak         |       |
//
// A pixel is accepted with its histogram read, then written back in S_UPD.
// After the last pixel the sequencer sweeps the histogram memory through its
// single read port: every bin for the first peak, every bin for the second
// peak (via the scoring unit), then the lower to upper peak span for the valley.
// Reset clears the histogram at once (per-bin valid bits), no sweep.
// A finished result sits in the output register; pixels are taken meanwhile,
// and only the next frame's result waits for it to drain.
// ----------------------------------------------------------------------------
module two_peaks_histogram_threshold
    import tpht_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PIX_W-1:0]   s_tdata,   // [7:0] pixel_value
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [3*OUT_W-1:0] m_tdata    // threshold_level, first_peak, second_peak
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_P1,
        S_P2,
        S_P2_DRAIN,
        S_TH,
        S_DONE
    } state_t;

    localparam bin_t LAST_BIN = bin_t'(NUM_BINS - 1);

    state_t             state_reg, state_next;
    bin_t               scan_addr_reg, scan_addr_next;
    logic               issue_done_reg, issue_done_next;
    logic               arr_valid_reg, arr_valid_next;
    bin_t               arr_idx_reg, arr_idx_next;
    bin_t               pix_reg, pix_next;
    logic               in_range_reg, in_range_next;
    logic               last_reg, last_next;
    count_t             max_count_reg, max_count_next;
    bin_t               first_reg, first_next;
    count_t             cm1_reg, cm1_next;
    count_t             cm2_reg, cm2_next;
    bin_t               best_k_reg, best_k_next;
    score_t             best_score_reg, best_score_next;
    bin_t               cut_reg, cut_next;
    count_t             cut_count_reg, cut_count_next;
    bin_t               lo_reg, lo_next;
    bin_t               hi_reg, hi_next;
    logic               out_valid_reg, out_valid_next;
    logic [3*OUT_W-1:0] out_data_reg, out_data_next;

    mem_req_t   mreq;
    count_t     rd_data;
    score_req_t sreq;
    score_rsp_t srsp;
    logic       score_busy;

    logic   s_accept;
    logic   done_load;
    logic   scanning;
    logic   issue;
    bin_t   scan_end;
    bin_t   pix_addr;
    logic   pix_in_range;
    bin_t   ev_idx;
    logic   local_max;
    bin_t   pk_lo;
    bin_t   pk_hi;

    tpht_hist_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .rd_data (rd_data)
    );

    tpht_score u_score (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sreq),
        .rsp   (srsp),
        .busy  (score_busy)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign done_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign pix_addr     = bin_t'(s_tdata);
    assign pix_in_range = (32'(s_tdata) < 32'(NUM_BINS));

    assign scanning = (state_reg == S_P1) || (state_reg == S_P2) || (state_reg == S_TH);
    assign issue    = scanning && !issue_done_reg;
    assign scan_end = (state_reg == S_TH) ? (hi_reg - 1'b1) : LAST_BIN;

    // histogram port: pixel read on accept, scan reads otherwise
    always_comb
    begin
        mreq.rd_en   = s_accept || issue;
        mreq.rd_addr = s_accept ? pix_addr : scan_addr_reg;
        mreq.wr_en   = (state_reg == S_UPD) && in_range_reg;
        mreq.wr_addr = pix_reg;
        mreq.wr_data = (rd_data == '1) ? rd_data : rd_data + 1'b1;
        mreq.clear   = done_load;
    end

    // second-peak candidates: bin 0 always, bin m-1 if a local max once bin m has arrived
    assign ev_idx    = (arr_idx_reg == '0) ? '0 : arr_idx_reg - 1'b1;
    assign local_max = (cm2_reg <= cm1_reg) && (rd_data <= cm1_reg);

    always_comb
    begin
        sreq.valid = (state_reg == S_P2) && arr_valid_reg
                     && ((arr_idx_reg == '0) || ((arr_idx_reg != bin_t'(1)) && local_max));
        sreq.idx   = ev_idx;
        sreq.delta = (ev_idx >= first_reg) ? (ev_idx - first_reg) : (first_reg - ev_idx);
        sreq.count = (arr_idx_reg == '0) ? rd_data : cm1_reg;
    end

    assign pk_lo = (first_reg < best_k_reg) ? first_reg : best_k_reg;
    assign pk_hi = (first_reg < best_k_reg) ? best_k_reg : first_reg;

    always_comb
    begin
        state_next      = state_reg;
        scan_addr_next  = scan_addr_reg;
        issue_done_next = issue_done_reg;
        arr_valid_next  = issue;
        arr_idx_next    = scan_addr_reg;
        pix_next        = pix_reg;
        in_range_next   = in_range_reg;
        last_next       = last_reg;
        max_count_next  = max_count_reg;
        first_next      = first_reg;
        cm1_next        = cm1_reg;
        cm2_next        = cm2_reg;
        best_k_next     = best_k_reg;
        best_score_next = best_score_reg;
        cut_next        = cut_reg;
        cut_count_next  = cut_count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (issue)
        begin
            scan_addr_next = scan_addr_reg + 1'b1;
            if (scan_addr_reg == scan_end)
            begin
                issue_done_next = 1'b1;
            end
        end

        if (srsp.valid && (srsp.score > best_score_reg))
        begin
            best_k_next     = srsp.idx;
            best_score_next = srsp.score;
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    pix_next      = pix_addr;
                    in_range_next = pix_in_range;
                    last_next     = s_tlast;
                    state_next    = S_UPD;
                end
            end
            S_UPD:
            begin
                if (last_reg)
                begin
                    scan_addr_next  = '0;
                    issue_done_next = 1'b0;
                    max_count_next  = '0;
                    first_next      = '0;
                    state_next      = S_P1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_P1:
            begin
                if (arr_valid_reg)
                begin
                    if (rd_data > max_count_reg)
                    begin
                        max_count_next = rd_data;
                        first_next     = arr_idx_reg;
                    end
                    if (arr_idx_reg == LAST_BIN)
                    begin
                        scan_addr_next  = '0;
                        issue_done_next = 1'b0;
                        best_k_next     = '0;
                        best_score_next = '0;
                        state_next      = S_P2;
                    end
                end
            end
            S_P2:
            begin
                if (arr_valid_reg)
                begin
                    cm2_next = cm1_reg;
                    cm1_next = rd_data;
                    if (arr_idx_reg == LAST_BIN)
                    begin
                        state_next = S_P2_DRAIN;
                    end
                end
            end
            S_P2_DRAIN:
            begin
                if (!score_busy)
                begin
                    lo_next         = pk_lo;
                    hi_next         = pk_hi;
                    cut_next        = first_reg;
                    cut_count_next  = max_count_reg;
                    scan_addr_next  = pk_lo;
                    issue_done_next = 1'b0;
                    state_next      = (pk_lo == pk_hi) ? S_DONE : S_TH;
                end
            end
            S_TH:
            begin
                if (arr_valid_reg)
                begin
                    if (rd_data < cut_count_reg)
                    begin
                        cut_next       = arr_idx_reg;
                        cut_count_next = rd_data;
                    end
                    if (arr_idx_reg == (hi_reg - 1'b1))
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (done_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {OUT_W'(best_k_reg), OUT_W'(first_reg), OUT_W'(cut_reg)};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_addr_reg  <= '0;
            issue_done_reg <= 1'b1;
            arr_valid_reg  <= 1'b0;
            arr_idx_reg    <= '0;
            pix_reg        <= '0;
            in_range_reg   <= 1'b0;
            last_reg       <= 1'b0;
            max_count_reg  <= '0;
            first_reg      <= '0;
            cm1_reg        <= '0;
            cm2_reg        <= '0;
            best_k_reg     <= '0;
            best_score_reg <= '0;
            cut_reg        <= '0;
            cut_count_reg  <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_addr_reg  <= scan_addr_next;
            issue_done_reg <= issue_done_next;
            arr_valid_reg  <= arr_valid_next;
            arr_idx_reg    <= arr_idx_next;
            pix_reg        <= pix_next;
            in_range_reg   <= in_range_next;
            last_reg       <= last_next;
            max_count_reg  <= max_count_next;
            first_reg      <= first_next;
            cm1_reg        <= cm1_next;
            cm2_reg        <= cm2_next;
            best_k_reg     <= best_k_next;
            best_score_reg <= best_score_next;
            cut_reg        <= cut_next;
            cut_count_reg  <= cut_count_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

    // a pixel is followed by its write-back cycle
    a_upd_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_UPD && !s_tready))
        else $error("pixel accept not followed by histogram update");

    // scoring unit only carries work during the second-peak sweep
    a_score_scope: assert property (@(posedge clk) disable iff (!rst_n)
        score_busy |-> (state_reg == S_P2 || state_reg == S_P2_DRAIN))
        else $error("scoring unit active outside second-peak sweep");

    // valley lies in [lower peak, upper peak) unless it stayed at the first peak
    a_cut_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |->
            (cut_reg == first_reg || (cut_reg >= lo_reg && cut_reg < hi_reg)))
        else $error("threshold outside the peak span");

    // no histogram write while a result is being loaded and the bins cleared
    a_no_wr_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
        mreq.clear |-> !mreq.wr_en && !s_tready)
        else $error("histogram write during clear");

endmodule

### hw/rtl/tpht_hist_mem.sv
// ----------------------------------------------------------------------------
// tpht_hist_mem
// Histogram storage: one count per bin, registered read, per-bin valid bits.
// An entry whose valid bit is clear reads as zero; clear drops all of them.
// ----------------------------------------------------------------------------
module tpht_hist_mem
    import tpht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output count_t   rd_data
);

    count_t              mem [NUM_BINS];
    logic [NUM_BINS-1:0] valid_reg;
    count_t              rd_data_reg;
    logic                rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

### hw/rtl/tpht_score.sv
// ----------------------------------------------------------------------------
// tpht_score
// Shared scoring unit: dist*dist, then times count, one register per product.
// Takes one bin per cycle; the result leaves prod_reg after d2_reg, exact at full width.
// ----------------------------------------------------------------------------
module tpht_score
    import tpht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  score_req_t req,
    output score_rsp_t rsp,
    output logic       busy
);

    logic   v1_reg;
    logic   v2_reg;
    bin_t   idx1_reg;
    bin_t   idx2_reg;
    dist2_t d2_reg;
    count_t cnt1_reg;
    score_t prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= req.idx;
        d2_reg   <= dist2_t'(req.delta) * dist2_t'(req.delta);
        cnt1_reg <= req.count;
        idx2_reg <= idx1_reg;
        prod_reg <= score_t'(d2_reg) * score_t'(cnt1_reg);
    end

    assign rsp.valid = v2_reg;
    assign rsp.idx   = idx2_reg;
    assign rsp.score = prod_reg;
    assign busy      = v1_reg | v2_reg;

endmodule

### verif/tb_two_peaks_histogram_threshold.sv
// ----------------------------------------------------------------------------
// tb_two_peaks_histogram_threshold
// Streams gray frames into the histogram threshold block. A directed table
// covers the edge cases, then random frames follow (uniform, two-cluster and
// plateau shapes), with random idle bursts on both sides. Each result word is
// checked field by field against an in-bench histogram model or a typed-in word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_two_peaks_histogram_threshold;
    import tpht_pkg::*;

    localparam int N_RANDOM = 550;
    localparam int N_QUIET  = 60;   // final stretch with no idling
    localparam int N_DIR    = 21;

    // packed so that the cast from m_tdata lands threshold_level in the low byte
    typedef struct packed {
        logic [OUT_W-1:0] second_peak;
        logic [OUT_W-1:0] first_peak;
        logic [OUT_W-1:0] threshold_level;
    } result_t;

    typedef struct {
        logic [PIX_W-1:0] pix;
        bit               last;
        bit               fixed;   // want is typed in, not predicted
        result_t          want;
    } stim_row_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [PIX_W-1:0]   s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [3*OUT_W-1:0] m_tdata;

    count_t  hist [NUM_BINS];
    result_t result_q [$];
    int      err_cnt   = 0;
    int      n_pixels  = 0;
    int      n_frames  = 0;
    int      n_checked = 0;
    bit      idle_on   = 1'b1;
    int      src_gap_pct = 20;

    // rows: single pixel at each extreme, bin 0 winning without being a
    // local max, a tie in score, and a plain two-cluster frame
    stim_row_t dir_tab [N_DIR] = '{
        '{8'd0,   1'b1, 1'b1, 24'h00_00_00},
        '{8'd255, 1'b1, 1'b1, 24'h00_FF_00},   // sp 0, fp 255, thr 0
        '{8'd0,   1'b0, 1'b0, 24'h0},
        '{8'd0,   1'b0, 1'b0, 24'h0},
        '{8'd0,   1'b0, 1'b0, 24'h0},
        '{8'd1,   1'b0, 1'b0, 24'h0},
        '{8'd1,   1'b0, 1'b0, 24'h0},
        '{8'd1,   1'b0, 1'b0, 24'h0},
        '{8'd1,   1'b1, 1'b0, 24'h0},
        '{8'd90,  1'b0, 1'b0, 24'h0},
        '{8'd100, 1'b0, 1'b0, 24'h0},
        '{8'd100, 1'b0, 1'b0, 24'h0},
        '{8'd100, 1'b0, 1'b0, 24'h0},
        '{8'd100, 1'b0, 1'b0, 24'h0},
        '{8'd110, 1'b1, 1'b0, 24'h0},
        '{8'd10,  1'b0, 1'b0, 24'h0},
        '{8'd10,  1'b0, 1'b0, 24'h0},
        '{8'd10,  1'b0, 1'b0, 24'h0},
        '{8'd200, 1'b0, 1'b0, 24'h0},
        '{8'd200, 1'b0, 1'b0, 24'h0},
        '{8'd100, 1'b1, 1'b0, 24'h0}
    };

    two_peaks_histogram_threshold dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb_two_peaks_histogram_threshold: done, errors");
        $finish;
    end

    // Counts one pixel; on the last pixel of a frame picks the three bins,
    // clears the histogram and returns 1.
    function automatic bit hist_count(input logic [PIX_W-1:0] pix, input bit last,
                                      output result_t res);
        int              pk1;
        int              pk2;
        int              cut;
        int              lo_b;
        int              hi_b;
        longint unsigned d;
        longint unsigned best;
        longint unsigned sc;
        res = '0;
        if (int'(pix) < NUM_BINS && hist[pix] != '1)
            hist[pix] = hist[pix] + 1'b1;
        if (!last)
            return 1'b0;

        pk1 = 0;
        for (int i = 0; i < NUM_BINS; i++)
            if (hist[i] > hist[pk1])
                pk1 = i;

        // bin 0 competes even when it is not a local max
        pk2  = 0;
        d    = longint'(pk1);
        best = d * d * longint'(hist[0]);
        for (int i = 1; i + 1 < NUM_BINS; i++)
        begin
            if (hist[i-1] <= hist[i] && hist[i+1] <= hist[i])
            begin
                d  = (i > pk1) ? longint'(i - pk1) : longint'(pk1 - i);
                sc = d * d * longint'(hist[i]);
                if (sc > best)
                begin
                    pk2  = i;
                    best = sc;
                end
            end
        end

        cut  = pk1;
        lo_b = (pk1 < pk2) ? pk1 : pk2;
        hi_b = (pk1 < pk2) ? pk2 : pk1;
        for (int i = lo_b; i < hi_b; i++)
            if (hist[i] < hist[cut])
                cut = i;

        res.threshold_level = cut[OUT_W-1:0];
        res.first_peak      = pk1[OUT_W-1:0];
        res.second_peak     = pk2[OUT_W-1:0];
        for (int i = 0; i < NUM_BINS; i++)
            hist[i] = '0;
        return 1'b1;
    endfunction

    // Entered and left at a falling edge; valid stays high between words
    // unless an idle burst is picked.
    task automatic put_pixel(input logic [PIX_W-1:0] pix, input bit last,
                             input bit fixed, input result_t fixed_res);
        result_t res;
        if (idle_on && $urandom_range(0, 99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_pixels++;
        if (hist_count(pix, last, res))
        begin
            n_frames++;
            result_q.push_back(fixed ? fixed_res : res);
        end
        @(negedge clk);
    endtask

    // result side: random stalls, rate changing now and then
    initial
    begin
        int sink_pct;
        sink_pct = 15;
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 199) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: sink_pct = 0;
                    1: sink_pct = 5;
                    default: sink_pct = 35;
                endcase
            end
            if (idle_on && $urandom_range(0, 99) < sink_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata);
            if (result_q.size() == 0)
            begin
                $error("result word %h with no frame pending", m_tdata);
                err_cnt++;
            end
            else
            begin
                want = result_q.pop_front();
                n_checked++;
                if (got.threshold_level !== want.threshold_level)
                begin
                    $error("threshold_level: expected %0d, actual %0d",
                           want.threshold_level, got.threshold_level);
                    err_cnt++;
                end
                if (got.first_peak !== want.first_peak)
                begin
                    $error("first_peak: expected %0d, actual %0d",
                           want.first_peak, got.first_peak);
                    err_cnt++;
                end
                if (got.second_peak !== want.second_peak)
                begin
                    $error("second_peak: expected %0d, actual %0d",
                           want.second_peak, got.second_peak);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        int               sent;
        int               flen;
        int               shape;
        int               c1;
        int               c2;
        int               spread;
        int               v;
        int               guard;
        logic [PIX_W-1:0] pix;
        for (int i = 0; i < NUM_BINS; i++)
            hist[i] = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[r])
            put_pixel(dir_tab[r].pix, dir_tab[r].last, dir_tab[r].fixed, dir_tab[r].want);

        sent = 0;
        while (sent < N_RANDOM)
        begin
            flen   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 16);
            shape  = $urandom_range(0, 3);
            c1     = $urandom_range(0, 255);
            c2     = $urandom_range(0, 255);
            spread = $urandom_range(0, 6);
            case ($urandom_range(0, 2))
                0: src_gap_pct = 0;
                1: src_gap_pct = 10;
                default: src_gap_pct = 40;
            endcase
            for (int p = 0; p < flen; p++)
            begin
                if (sent >= N_RANDOM - N_QUIET)
                    idle_on = 1'b0;
                case (shape)
                    0: v = $urandom_range(0, 255);
                    3: v = c1 + spread * $urandom_range(0, 3);   // few levels, many ties
                    default:
                    begin
                        v = ($urandom_range(0, 1) ? c1 : c2)
                            + $urandom_range(0, 2 * spread) - spread;
                    end
                endcase
                guard = (v < 0) ? 0 : (v > 255) ? 255 : v;
                pix   = guard[PIX_W-1:0];
                put_pixel(pix, p == flen - 1, 1'b0, '0);
                sent++;
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (result_q.size() != 0)
            @(posedge clk);
        // room for a stray word from a full sweep
        repeat (1100) @(posedge clk);

        $display("covered %0d pixels in %0d frames, %0d result words checked",
                 n_pixels, n_frames, n_checked);
        if (err_cnt == 0)
            $display("tb_two_peaks_histogram_threshold: done, clean");
        else
            $display("tb_two_peaks_histogram_threshold: done, errors");
        $finish;
    end

endmodule
